// File: design/hall_sector_decoder_period_capture_top_defines.svh
`ifndef HALL_SECTOR_DECODER_PERIOD_CAPTURE_TOP_DEFINES_SVH
`define HALL_SECTOR_DECODER_PERIOD_CAPTURE_TOP_DEFINES_SVH

// concurrent check on clk, idle while arst_n is low
`define HSDPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication check on clk, idle while arst_n is low
`define HSDPC_ASSERT_IMP(label, ante, cons, msg) \
	`HSDPC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: design/hsdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsdpc_pkg;

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned ANGLE_W = 9;
	localparam int unsigned DELTA_W = 10;
	localparam int unsigned SLOT_W  = 3;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_HALL = 2'd1,
		KIND_INIT = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	localparam logic [ANGLE_W-1:0] ANGLE_0   = 9'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_60  = 9'd60;
	localparam logic [ANGLE_W-1:0] ANGLE_120 = 9'd120;
	localparam logic [ANGLE_W-1:0] ANGLE_180 = 9'd180;
	localparam logic [ANGLE_W-1:0] ANGLE_240 = 9'd240;
	localparam logic [ANGLE_W-1:0] ANGLE_300 = 9'd300;

	localparam logic [CNT_W-1:0] PERIOD_RESET = 16'hFFFF;

	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] value;
	} cap_t;

	typedef struct packed {
		logic               ok;
		logic [ANGLE_W-1:0] angle;
	} sector_t;

	// code is {a, b, c}
	function automatic sector_t decode_sector(input logic [2:0] code);
		sector_t r;
		r.ok    = 1'b1;
		r.angle = ANGLE_0;
		unique case (code)
			3'd5: r.angle = ANGLE_0;
			3'd4: r.angle = ANGLE_60;
			3'd6: r.angle = ANGLE_120;
			3'd2: r.angle = ANGLE_180;
			3'd3: r.angle = ANGLE_240;
			3'd1: r.angle = ANGLE_300;
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/hsdpc_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module hsdpc_ring #(
	parameter int unsigned RING_DEPTH = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hsdpc_pkg::cap_t                 cap,
	input  wire logic [hsdpc_pkg::SLOT_W-1:0]    read_slot,
	output logic      [hsdpc_pkg::CNT_W-1:0]     slot_interval,
	output logic      [hsdpc_pkg::SLOT_W-1:0]    next_slot
);

	localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [hsdpc_pkg::CNT_W-1:0] ring_q [RING_DEPTH];
	logic [IDX_W-1:0]            wr_idx_q;
	logic [IDX_W-1:0]            wr_idx_next;
	logic [IDX_W-1:0]            rd_idx;
	logic                        rd_ok;

	always_comb begin
		wr_idx_next = wr_idx_q;
		if (cap.en) begin
			wr_idx_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			wr_idx_q <= wr_idx_next;
			if (cap.en) begin
				ring_q[wr_idx_q] <= cap.value;
			end
		end
	end

	// read after this update: bypass the entry being written
	assign rd_ok  = 32'(read_slot) < RING_DEPTH;
	assign rd_idx = IDX_W'(read_slot);

	always_comb begin
		slot_interval = '0;
		if (rd_ok) begin
			slot_interval = (cap.en && rd_idx == wr_idx_q) ? cap.value : ring_q[rd_idx];
		end
	end

	assign next_slot = hsdpc_pkg::SLOT_W'(wr_idx_next);

endmodule

`default_nettype wire

// File: design/hall_sector_decoder_period_capture_top.sv
// each item passes the input register, then the result register, before it is offered
// throughput: one item per cycle while results are taken, input register then result register
// s_tready drops only while the result register is full and not taken
// arst_n clears control state: period 65535, counter 0, ring zero, overrun set
// angle and delta reset to zero; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "hall_sector_decoder_period_capture_top_defines.svh"

module hall_sector_decoder_period_capture_top #(
	parameter int unsigned RING_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // hall_a, hall_b, hall_c, read_slot[2:0], zeros
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // angle_deg[8:0], delta_angle[9:0], overrun,
	                                    // timeout_now, slot_interval[15:0], next_slot[2:0]
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata  // timeout_period
);

	localparam int unsigned CNT_W   = hsdpc_pkg::CNT_W;
	localparam int unsigned ANGLE_W = hsdpc_pkg::ANGLE_W;
	localparam int unsigned DELTA_W = hsdpc_pkg::DELTA_W;
	localparam int unsigned SLOT_W  = hsdpc_pkg::SLOT_W;

	logic                     valid_s1;
	hsdpc_pkg::kind_t         kind_s1;
	logic [2:0]               hall_s1;
	logic [SLOT_W-1:0]        slot_s1;

	logic                     valid_s2;
	logic [39:0]              data_s2;

	logic [CNT_W-1:0]         period_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     overrun_q;
	logic [ANGLE_W-1:0]       angle_q;
	logic [DELTA_W-1:0]       delta_q;

	logic                     adv;
	logic                     in_xfer;
	logic [CNT_W:0]           cnt_inc;
	logic [CNT_W-1:0]         cnt_d;
	logic                     overrun_d;
	logic [ANGLE_W-1:0]       angle_d;
	logic [DELTA_W-1:0]       delta_d;
	logic                     timeout_d;
	hsdpc_pkg::cap_t          cap;
	hsdpc_pkg::sector_t       sector;
	logic [CNT_W-1:0]         slot_interval;
	logic [SLOT_W-1:0]        next_slot;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1 <= hsdpc_pkg::kind_t'(s_tuser);
			hall_s1 <= {s_tdata[0], s_tdata[1], s_tdata[2]};
			slot_s1 <= s_tdata[5:3];
		end
	end

	assign sector  = hsdpc_pkg::decode_sector(hall_s1);
	assign cnt_inc = {1'b0, cnt_q} + (CNT_W+1)'(1);

	always_comb begin
		cnt_d     = cnt_q;
		overrun_d = overrun_q;
		angle_d   = angle_q;
		delta_d   = delta_q;
		timeout_d = 1'b0;
		cap.en    = 1'b0;
		cap.value = cnt_q;
		unique case (kind_s1)
			hsdpc_pkg::KIND_TICK: begin
				if (cnt_inc >= {1'b0, period_q}) begin
					cnt_d     = '0;
					overrun_d = 1'b1;
					timeout_d = 1'b1;
					cap.en    = 1'b1;
					cap.value = period_q;
				end else begin
					cnt_d = cnt_inc[CNT_W-1:0];
				end
			end
			hsdpc_pkg::KIND_HALL: begin
				cap.en    = 1'b1;
				cnt_d     = '0;
				overrun_d = 1'b0;
				if (sector.ok) begin
					angle_d = sector.angle;
				end
				delta_d = DELTA_W'(angle_d) - DELTA_W'(angle_q);
			end
			hsdpc_pkg::KIND_INIT: begin
				if (sector.ok) begin
					angle_d = sector.angle;
				end
			end
			default: begin
			end
		endcase
		if (!adv) begin
			cap.en = 1'b0;
		end
	end

	hsdpc_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.cap          (cap),
		.read_slot    (slot_s1),
		.slot_interval(slot_interval),
		.next_slot    (next_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= hsdpc_pkg::PERIOD_RESET;
			cnt_q     <= '0;
			overrun_q <= 1'b1;
			angle_q   <= '0;
			delta_q   <= '0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (adv) begin
				cnt_q     <= cnt_d;
				overrun_q <= overrun_d;
				angle_q   <= angle_d;
				delta_q   <= delta_d;
				valid_s2  <= 1'b1;
			end else if (m_tready) begin
				valid_s2  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {next_slot, slot_interval, timeout_d, overrun_d, delta_d, angle_d};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	`HSDPC_ASSERT_IMP(a_timeout_sets_overrun, valid_s2 && data_s2[20], data_s2[19],
		"timeout result without overrun")
	`HSDPC_ASSERT_IMP(a_angle_sector, valid_s2,
		data_s2[8:0] == hsdpc_pkg::ANGLE_0 || data_s2[8:0] == hsdpc_pkg::ANGLE_60 ||
		data_s2[8:0] == hsdpc_pkg::ANGLE_120 || data_s2[8:0] == hsdpc_pkg::ANGLE_180 ||
		data_s2[8:0] == hsdpc_pkg::ANGLE_240 || data_s2[8:0] == hsdpc_pkg::ANGLE_300,
		"angle is not a sector angle")
	`HSDPC_ASSERT(a_hall_clears, adv && kind_s1 == hsdpc_pkg::KIND_HALL |=>
		!overrun_q && cnt_q == '0, "hall change did not clear counter and overrun")
	`HSDPC_ASSERT(a_timeout_wraps, adv && timeout_d |=> cnt_q == '0 && overrun_q,
		"timeout did not wrap the counter")

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CNT_W   = hsdpc_pkg::CNT_W;
	localparam int unsigned ANGLE_W = hsdpc_pkg::ANGLE_W;
	localparam int unsigned DELTA_W = hsdpc_pkg::DELTA_W;
	localparam int unsigned SLOT_W  = hsdpc_pkg::SLOT_W;

	localparam int unsigned SLOTS = 8;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam logic [2:0] SECTOR_CODES [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};
	localparam logic [CNT_W-1:0] PERIOD_PLAN [12] = '{
		16'hFFFF, 16'd1, 16'd9, 16'd25,
		16'd0, 16'd4, 16'd30, 16'd12,
		16'd2, 16'd16, 16'd1, 16'hFFFF
	};
	localparam int unsigned SEND_IDLE [3] = '{11, 86, 0};
	localparam int unsigned RECV_IDLE [3] = '{86, 11, 0};

	typedef struct packed {
		logic [SLOT_W-1:0]  next_slot;
		logic [CNT_W-1:0]   slot_interval;
		logic               timeout_now;
		logic               overrun;
		logic [DELTA_W-1:0] delta;
		logic [ANGLE_W-1:0] angle;
	} reading_t;

	class sector_scoreboard;
		logic [CNT_W-1:0]   period;
		logic [CNT_W-1:0]   counter;
		logic [CNT_W-1:0]   ring [SLOTS];
		logic [SLOT_W-1:0]  wr;
		logic               overrun;
		logic [ANGLE_W-1:0] angle;
		logic [DELTA_W-1:0] delta;
		reading_t           pending [$];
		int                 failures;

		function new();
			period   = hsdpc_pkg::PERIOD_RESET;
			counter  = '0;
			foreach (ring[i]) ring[i] = '0;
			wr       = '0;
			overrun  = 1'b1;
			angle    = hsdpc_pkg::ANGLE_0;
			delta    = '0;
			failures = 0;
		endfunction

		function void set_period(logic [CNT_W-1:0] value);
			period = value;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function logic [ANGLE_W-1:0] sector_of(logic [2:0] code, logic [ANGLE_W-1:0] held);
			case (code)
				3'd5: return hsdpc_pkg::ANGLE_0;
				3'd4: return hsdpc_pkg::ANGLE_60;
				3'd6: return hsdpc_pkg::ANGLE_120;
				3'd2: return hsdpc_pkg::ANGLE_180;
				3'd3: return hsdpc_pkg::ANGLE_240;
				3'd1: return hsdpc_pkg::ANGLE_300;
				default: return held;
			endcase
		endfunction

		function void store_interval(logic [CNT_W-1:0] value);
			ring[wr] = value;
			wr = (wr == SLOT_W'(SLOTS - 1)) ? '0 : wr + 1'b1;
		endfunction

		function void note_sample(hsdpc_pkg::kind_t kind, logic [2:0] code,
			logic [SLOT_W-1:0] slot);
			reading_t           r;
			logic [CNT_W:0]     nxt;
			logic [ANGLE_W-1:0] prev;
			r.timeout_now = 1'b0;
			case (kind)
				hsdpc_pkg::KIND_TICK: begin
					nxt = {1'b0, counter} + 1'b1;
					if (nxt >= {1'b0, period}) begin
						counter = '0;
						overrun = 1'b1;
						store_interval(period);
						r.timeout_now = 1'b1;
					end else begin
						counter = nxt[CNT_W-1:0];
					end
				end
				hsdpc_pkg::KIND_HALL: begin
					prev = angle;
					store_interval(counter);
					counter = '0;
					overrun = 1'b0;
					angle = sector_of(code, angle);
					delta = DELTA_W'(angle) - DELTA_W'(prev);
				end
				hsdpc_pkg::KIND_INIT: angle = sector_of(code, angle);
				default: ;
			endcase
			r.angle         = angle;
			r.delta         = delta;
			r.overrun       = overrun;
			r.slot_interval = (slot < SLOTS) ? ring[slot] : '0;
			r.next_slot     = wr;
			pending.push_back(r);
		endfunction

		function void check_reading(logic [39:0] raw);
			reading_t seen;
			reading_t want;
			bit       ok;
			seen = raw;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result transfer %h", raw);
				return;
			end
			want = pending.pop_front();
			ok = (seen.angle === want.angle) && (seen.delta === want.delta)
				&& (seen.overrun === want.overrun) && (seen.timeout_now === want.timeout_now)
				&& (seen.slot_interval === want.slot_interval)
				&& (seen.next_slot === want.next_slot);
			if (!ok) begin
				failures++;
				if (failures <= 10)
					$display({"mismatch exp/act: angle %0d/%0d delta %0d/%0d ovr %b/%b ",
						"tmo %b/%b slot_iv %0d/%0d next %0d/%0d"},
						want.angle, seen.angle, $signed(want.delta), $signed(seen.delta),
						want.overrun, seen.overrun, want.timeout_now, seen.timeout_now,
						want.slot_interval, seen.slot_interval, want.next_slot, seen.next_slot);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned stall_cycles = 0;
	int          hall_pos = 0;

	sector_scoreboard board = new();

	hall_sector_decoder_period_capture_top #(.RING_DEPTH(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_reading(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	task automatic send_sample(input hsdpc_pkg::kind_t kind, input logic [2:0] code,
		input logic [SLOT_W-1:0] slot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		// hall_a is the top code bit but sits in bit 0
		s_tdata  <= {2'b00, slot, code[0], code[1], code[2]};
		do @(posedge clk); while (!s_tready);
		board.note_sample(kind, code, slot);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_period(value);
	endtask

	// a run of ticks usually closed by a hall transition, mostly to the neighbouring sector
	task automatic run_burst(output int count);
		int span;
		int ticks;
		int pick;
		int step;
		span  = (board.period != 0 && board.period < 40) ? 2 * board.period + 2 : 40;
		ticks = $urandom_range(span);
		count = 0;
		repeat (ticks) begin
			send_sample(hsdpc_pkg::KIND_TICK, 3'($urandom), 3'($urandom));
			count++;
		end
		pick = $urandom_range(99);
		if (pick < 75) begin
			step = (pick < 55) ? 1 : (pick < 68) ? 5 : $urandom_range(5);
			hall_pos = (hall_pos + step) % 6;
			send_sample(hsdpc_pkg::KIND_HALL, SECTOR_CODES[hall_pos], 3'($urandom));
			count++;
		end else if (pick < 85) begin
			send_sample(hsdpc_pkg::KIND_HALL, 3'($urandom), 3'($urandom));
			count++;
		end else if (pick < 95) begin
			send_sample(hsdpc_pkg::KIND_INIT, 3'($urandom), 3'($urandom));
			count++;
		end else begin
			send_sample(hsdpc_pkg::KIND_NONE, 3'($urandom), 3'($urandom));
		end
	endtask

	initial begin
		int sent;
		int got;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, every hall code through the initial read
		send_idle_pct = 11;
		recv_idle_pct = 86;
		send_sample(hsdpc_pkg::KIND_NONE, 3'd0, 3'd7);
		for (int c = 0; c < 8; c++)
			send_sample(hsdpc_pkg::KIND_INIT, 3'(c), 3'(c));

		write_period(16'd3);
		send_sample(hsdpc_pkg::KIND_HALL, 3'd5, 3'd0);
		send_sample(hsdpc_pkg::KIND_HALL, 3'd1, 3'd1);
		send_sample(hsdpc_pkg::KIND_HALL, 3'd5, 3'd2);
		for (int i = 1; i < 6; i++)
			send_sample(hsdpc_pkg::KIND_HALL, SECTOR_CODES[i], 3'(i));
		send_sample(hsdpc_pkg::KIND_HALL, 3'd0, 3'd7);
		send_sample(hsdpc_pkg::KIND_HALL, 3'd7, 3'd0);
		repeat (4) send_sample(hsdpc_pkg::KIND_TICK, 3'd7, 3'd1);
		send_sample(hsdpc_pkg::KIND_NONE, 3'd7, 3'd2);
		send_sample(hsdpc_pkg::KIND_HALL, 3'd5, 3'd3);

		for (int phase = 0; phase < 3; phase++) begin
			for (int k = 0; k < 4; k++) begin
				write_period(PERIOD_PLAN[phase * 4 + k]);
				send_idle_pct = SEND_IDLE[phase];
				recv_idle_pct = RECV_IDLE[phase];
				sent = 0;
				while (sent < 144) begin
					run_burst(got);
					sent += got;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (board.failures == 0 && board.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
